// ----- hdl/msd_pkg.sv -----
// Shared types and constants for the block mean / variance / deviation unit.
package msd_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int MAX_SAMPLES_DEF = 4096;

  // Fixed result field widths.
  localparam int VAR_W = 31;
  localparam int STD_W = 16;
  localparam logic [VAR_W-1:0] VAR_MAX = {VAR_W{1'b1}};

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ,
    S_ACC,
    S_MUL_N,
    S_MUL_S,
    S_SUBN,
    S_MUL_D,
    S_DIVV,
    S_SQRT,
    S_DIVM,
    S_NEGM,
    S_DONE
  } state_t;

endpackage

// ----- hdl/msd_alu.sv -----
// Shared add / subtract unit with unsigned compare flag.
module msd_alu #(
  parameter int W = 8
) (
  input  msd_pkg::alu_op_t op,
  input  logic [W-1:0]     a,
  input  logic [W-1:0]     b,
  output logic [W-1:0]     res,
  output logic             ge
);
  import msd_pkg::*;

  logic [W:0] sum;
  logic [W:0] diff;

  assign sum  = {1'b0, a} + {1'b0, b};
  assign diff = {1'b0, a} - {1'b0, b};
  // No borrow means a >= b.
  assign ge   = ~diff[W];

  always_comb begin
    case (op)
      ALU_ADD: res = sum[W-1:0];
      ALU_SUB: res = diff[W-1:0];
      default: res = sum[W-1:0];
    endcase
  end

endmodule

// ----- hdl/block_mean_variance_stddev_unit.sv -----
// Top level: block mean, sample variance and standard deviation over a sample stream.
//
//  channel | dir | handshake           | content
//  --------+-----+---------------------+------------------------------------------
//  in_     | in  | tvalid/tready/tlast | tdata = sample; tlast = last sample of block
//  out_    | out | tvalid/tready       | tdata = mean, variance, std_dev, count
//
//  A sample is taken in S_IDLE, squared by shift-add through the shared adder in S_SQ,
//  and added into the square sum in S_ACC; no new sample is taken until then. A closing
//  sample then runs the bit-serial multiplies, two restoring divides and the square root
//  (a one-sample block only the mean divide), all on the one adder. rst_n is synchronous
//  and clears the accumulators and the handshake. The result waits in an output register;
//  the next sample is taken while it waits, and only the next block end stalls on it.
module block_mean_variance_stddev_unit #(
  parameter int SAMPLE_BITS = msd_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_SAMPLES = msd_pkg::MAX_SAMPLES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  // [SAMPLE_BITS-1:0] sample, zero fill to bytes
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic in_tlast,
  // from bit 0: mean (SAMPLE_BITS), variance (31), std_dev (16), count, zero fill
  output logic [((SAMPLE_BITS+msd_pkg::VAR_W+msd_pkg::STD_W
                  +$clog2(MAX_SAMPLES+1)+7)/8)*8-1:0] out_tdata,
  output logic out_tvalid,
  input  logic out_tready
);
  import msd_pkg::*;

  localparam int CNT_W  = $clog2(MAX_SAMPLES+1);
  localparam int SUM_W  = SAMPLE_BITS + CNT_W;
  localparam int SSQ_W  = 2*SAMPLE_BITS + CNT_W - 2;
  // Datapath width: holds n*sumsq and sum^2.
  localparam int W      = 2*CNT_W + 2*SAMPLE_BITS - 2;
  localparam int ITER_W = $clog2(W+1);
  localparam int SQ_W   = 2*STD_W;
  localparam int RES_W  = SAMPLE_BITS + VAR_W + STD_W + CNT_W;
  localparam int OUT_W  = ((RES_W+7)/8)*8;

  state_t state_r, state_nxt;

  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [SSQ_W-1:0]  ssq_r, ssq_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              last_r, last_nxt;
  logic [W-1:0]      mcand_r, mcand_nxt;
  logic [W-1:0]      mplier_r, mplier_nxt;
  logic [W-1:0]      acc_r, acc_nxt;
  logic [W-1:0]      num_r, num_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic [VAR_W-1:0]  var_r, var_nxt;
  logic [STD_W-1:0]  sd_r, sd_nxt;
  logic [SQ_W-1:0]   sq_r, sq_nxt;
  logic [SAMPLE_BITS-1:0] mean_r, mean_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [RES_W-1:0]  out_res_r, out_res_nxt;

  alu_op_t    alu_op;
  logic [W-1:0] alu_a, alu_b, alu_res;
  logic       alu_ge;

  logic [SAMPLE_BITS-1:0] in_sample, in_mag;
  logic [SUM_W-1:0]  smag;
  logic [W-1:0]      div_trial, sqrt_rem, sqrt_sub, quo;
  logic [W+VAR_W-1:0] quo_x;
  logic [VAR_W-1:0]  var_val;
  logic              last_iter, block_end;

  msd_alu #(.W(W)) u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .res(alu_res),
    .ge (alu_ge)
  );

  assign in_sample = in_tdata[SAMPLE_BITS-1:0];
  assign in_mag    = in_sample[SAMPLE_BITS-1] ? (~in_sample + 1'b1) : in_sample;
  assign smag      = sum_r[SUM_W-1] ? (~sum_r + 1'b1) : sum_r;
  assign last_iter = (iter_r == ITER_W'(1));
  assign block_end = last_r || (count_r == CNT_W'(MAX_SAMPLES));

  // Restoring divide step: remainder in acc, dividend / quotient in num.
  assign div_trial = {acc_r[W-2:0], num_r[W-1]};
  assign quo       = {num_r[W-2:0], alu_ge};
  assign quo_x     = {{VAR_W{1'b0}}, quo};
  assign var_val   = (|quo_x[W+VAR_W-1:VAR_W]) ? VAR_MAX : quo_x[VAR_W-1:0];

  // Square root step: two operand bits a cycle, root in mplier.
  assign sqrt_rem  = {acc_r[W-3:0], sq_r[SQ_W-1 -: 2]};
  assign sqrt_sub  = {mplier_r[W-3:0], 2'b01};

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_W-RES_W){1'b0}}, out_res_r};

  always_comb begin
    state_nxt      = state_r;
    sum_nxt        = sum_r;
    ssq_nxt        = ssq_r;
    count_nxt      = count_r;
    last_nxt       = last_r;
    mcand_nxt      = mcand_r;
    mplier_nxt     = mplier_r;
    acc_nxt        = acc_r;
    num_nxt        = num_r;
    iter_nxt       = iter_r;
    var_nxt        = var_r;
    sd_nxt         = sd_r;
    sq_nxt         = sq_r;
    mean_nxt       = mean_r;
    out_res_nxt    = out_res_r;
    out_tvalid_nxt = out_tvalid_r & ~out_tready;
    alu_op         = ALU_ADD;
    alu_a          = acc_r;
    alu_b          = mplier_r[0] ? mcand_r : '0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          sum_nxt    = sum_r + {{(SUM_W-SAMPLE_BITS){in_sample[SAMPLE_BITS-1]}}, in_sample};
          count_nxt  = count_r + 1'b1;
          last_nxt   = in_tlast;
          mcand_nxt  = {{(W-SAMPLE_BITS){1'b0}}, in_mag};
          mplier_nxt = {{(W-SAMPLE_BITS){1'b0}}, in_mag};
          acc_nxt    = '0;
          iter_nxt   = ITER_W'(SAMPLE_BITS);
          state_nxt  = S_SQ;
        end
      end

      // Shift-add multiply: acc += mplier[0] ? mcand : 0.
      S_SQ, S_MUL_N, S_MUL_S, S_MUL_D: begin
        acc_nxt    = alu_res;
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        iter_nxt   = iter_r - 1'b1;
        if (last_iter) begin
          case (state_r)
            S_SQ: state_nxt = S_ACC;
            S_MUL_N: begin
              num_nxt    = alu_res;
              mcand_nxt  = {{(W-SUM_W){1'b0}}, smag};
              mplier_nxt = {{(W-SUM_W){1'b0}}, smag};
              acc_nxt    = '0;
              iter_nxt   = ITER_W'(SUM_W);
              state_nxt  = S_MUL_S;
            end
            S_MUL_S: state_nxt = S_SUBN;
            S_MUL_D: begin
              mcand_nxt = alu_res;
              acc_nxt   = '0;
              iter_nxt  = ITER_W'(W);
              state_nxt = S_DIVV;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      S_ACC: begin
        alu_a   = {{(W-SSQ_W){1'b0}}, ssq_r};
        alu_b   = acc_r;
        ssq_nxt = alu_res[SSQ_W-1:0];
        if (!block_end) begin
          state_nxt = S_IDLE;
        end else if (count_r == CNT_W'(1)) begin
          // single sample: no spread
          var_nxt   = '0;
          sd_nxt    = '0;
          num_nxt   = {{(W-SUM_W){1'b0}}, smag};
          mcand_nxt = {{(W-CNT_W){1'b0}}, count_r};
          acc_nxt   = '0;
          iter_nxt  = ITER_W'(W);
          state_nxt = S_DIVM;
        end else begin
          mcand_nxt  = {{(W-SSQ_W){1'b0}}, alu_res[SSQ_W-1:0]};
          mplier_nxt = {{(W-CNT_W){1'b0}}, count_r};
          acc_nxt    = '0;
          iter_nxt   = ITER_W'(CNT_W);
          state_nxt  = S_MUL_N;
        end
      end

      // numerator = n*sumsq - sum^2
      S_SUBN: begin
        alu_op     = ALU_SUB;
        alu_a      = num_r;
        alu_b      = acc_r;
        num_nxt    = alu_res;
        mcand_nxt  = {{(W-CNT_W){1'b0}}, count_r};
        mplier_nxt = {{(W-CNT_W){1'b0}}, count_r - 1'b1};
        acc_nxt    = '0;
        iter_nxt   = ITER_W'(CNT_W);
        state_nxt  = S_MUL_D;
      end

      S_DIVV, S_DIVM: begin
        alu_op   = ALU_SUB;
        alu_a    = div_trial;
        alu_b    = mcand_r;
        acc_nxt  = alu_ge ? alu_res : div_trial;
        num_nxt  = quo;
        iter_nxt = iter_r - 1'b1;
        if (last_iter) begin
          if (state_r == S_DIVV) begin
            var_nxt    = var_val;
            sq_nxt     = SQ_W'(var_val);
            acc_nxt    = '0;
            mplier_nxt = '0;
            iter_nxt   = ITER_W'(STD_W);
            state_nxt  = S_SQRT;
          end else begin
            state_nxt = S_NEGM;
          end
        end
      end

      S_SQRT: begin
        alu_op     = ALU_SUB;
        alu_a      = sqrt_rem;
        alu_b      = sqrt_sub;
        acc_nxt    = alu_ge ? alu_res : sqrt_rem;
        mplier_nxt = {mplier_r[W-2:0], alu_ge};
        sq_nxt     = sq_r << 2;
        iter_nxt   = iter_r - 1'b1;
        if (last_iter) begin
          sd_nxt    = {mplier_r[STD_W-2:0], alu_ge};
          num_nxt   = {{(W-SUM_W){1'b0}}, smag};
          mcand_nxt = {{(W-CNT_W){1'b0}}, count_r};
          acc_nxt   = '0;
          iter_nxt  = ITER_W'(W);
          state_nxt = S_DIVM;
        end
      end

      // Restore the sign of the mean: truncation toward zero.
      S_NEGM: begin
        alu_op    = ALU_SUB;
        alu_a     = '0;
        alu_b     = num_r;
        mean_nxt  = sum_r[SUM_W-1] ? alu_res[SAMPLE_BITS-1:0] : num_r[SAMPLE_BITS-1:0];
        state_nxt = S_DONE;
      end

      // Hold until the output register is free, then issue and clear the block.
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_res_nxt    = {count_r, sd_r, var_r, mean_r};
          sum_nxt        = '0;
          ssq_nxt        = '0;
          count_nxt      = '0;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      sum_r        <= '0;
      ssq_r        <= '0;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sum_r        <= sum_nxt;
      ssq_r        <= ssq_nxt;
      count_r      <= count_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r    <= last_nxt;
    mcand_r   <= mcand_nxt;
    mplier_r  <= mplier_nxt;
    acc_r     <= acc_nxt;
    num_r     <= num_nxt;
    iter_r    <= iter_nxt;
    var_r     <= var_nxt;
    sd_r      <= sd_nxt;
    sq_r      <= sq_nxt;
    mean_r    <= mean_nxt;
    out_res_r <= out_res_nxt;
  end

endmodule
